// File: design/adaptive_bitrate_selector_defines.svh
// Assertion macros for the bitrate selector
`ifndef ADAPTIVE_BITRATE_SELECTOR_DEFINES_SVH
`define ADAPTIVE_BITRATE_SELECTOR_DEFINES_SVH

// same-cycle implication
`define ABRS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ABRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/abrs_pkg.sv
package abrs_pkg;

  localparam int MAX_VARIANTS_DEF = 8;

  localparam int MODE_W  = 3;
  localparam int IDX_W   = 3;
  localparam int BW_W    = 40;
  localparam int BYTE_W  = 32;
  localparam int TIME_W  = 48;
  localparam int TOTAL_W = 48;
  localparam int RATE_W  = 40;
  localparam int CNT_W   = 4;

  localparam int HALF_W  = TOTAL_W / 2;
  localparam int USEC_W  = 23;
  localparam int PROD_W  = HALF_W + USEC_W;
  localparam int NUM_W   = TOTAL_W + USEC_W;

  localparam logic [USEC_W-1:0] USEC_BITS = USEC_W'(8000000);

  localparam int S_TDATA_W = 128;
  localparam int M_TDATA_W = 88;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD   = 3'd0,
    MODE_BEGIN  = 3'd1,
    MODE_ADD    = 3'd2,
    MODE_FINISH = 3'd3,
    MODE_SELECT = 3'd4
  } mode_t;

  typedef enum logic {
    CFG_ENABLE = 1'b0,
    CFG_COUNT  = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rate_sts_t;

endpackage

// File: design/abrs_table.sv
module abrs_table
  import abrs_pkg::*;
#(
  parameter int DEPTH = MAX_VARIANTS_DEF,
  parameter int AW    = 3
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  logic [BW_W-1:0] wdata,
  input  logic [AW-1:0]   raddr,
  output logic [BW_W-1:0] rdata
);

  logic [BW_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: design/abrs_rate.sv
module abrs_rate
  import abrs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [TOTAL_W-1:0] total,
  input  logic [TIME_W-1:0]  span,
  output rate_sts_t          sts,
  output logic [RATE_W-1:0]  rate
);

  localparam int CW = $clog2(NUM_W);

  typedef enum logic [2:0] {
    R_IDLE, R_MLO, R_MHI, R_SUM, R_DIV, R_DONE
  } rstate_t;

  rstate_t              state;
  logic [TOTAL_W-1:0]   tot;
  logic [TIME_W-1:0]    divisor;
  logic [PROD_W-1:0]    prod;
  logic [NUM_W-1:0]     num;
  logic [TIME_W-1:0]    rem;
  logic [CW-1:0]        cnt;

  logic [HALF_W-1:0]    mult_a;
  logic [PROD_W-1:0]    mult;
  logic [TIME_W:0]      rem_sh;
  logic [TIME_W:0]      trial;
  logic                 ge;

  assign mult_a = (state == R_MLO) ? tot[HALF_W-1:0] : tot[TOTAL_W-1:HALF_W];
  assign mult   = PROD_W'(mult_a) * PROD_W'(USEC_BITS);
  assign rem_sh = {rem, num[NUM_W-1]};
  assign trial  = rem_sh - {1'b0, divisor};
  assign ge     = !trial[TIME_W];

  assign sts.busy = (state != R_IDLE);
  assign sts.done = (state == R_DONE);
  assign rate     = (|num[NUM_W-1:RATE_W]) ? {RATE_W{1'b1}} : num[RATE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= R_IDLE;
    end else begin
      case (state)
        R_IDLE: begin
          if (start) begin
            tot     <= total;
            divisor <= span;
            state   <= R_MLO;
          end
        end
        R_MLO: begin
          prod  <= mult;
          state <= R_MHI;
        end
        R_MHI: begin
          num   <= NUM_W'(prod);
          prod  <= mult;
          state <= R_SUM;
        end
        R_SUM: begin
          num   <= num + {prod, {HALF_W{1'b0}}};
          rem   <= '0;
          cnt   <= CW'(NUM_W - 1);
          state <= R_DIV;
        end
        R_DIV: begin
          rem <= ge ? trial[TIME_W-1:0] : rem_sh[TIME_W-1:0];
          num <= {num[NUM_W-2:0], ge};
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= R_DONE;
          end
        end
        R_DONE: begin
          state <= R_IDLE;
        end
        default: begin
          state <= R_IDLE;
        end
      endcase
    end
  end

endmodule

// File: design/adaptive_bitrate_selector.sv
// Throughput-based bitrate selector.
// Input stream (s_*): one request per control event; tuser carries the mode
// (load variant, begin measure, add bytes, finish measure, select) and tdata
// the slot, bandwidth, byte count and timestamp. Output stream (m_*): one
// result per request with the selected index and bandwidth, the last measured
// rate and a switched flag.
// Configuration: cfg_we/cfg_index/cfg_data write adaptive_enable (index 0)
// and variant_count (index 1); write only while the block is idle.
// Load, begin and add requests pass from acceptance through the execute
// and done states to m_tvalid; a select that may change the selection also
// passes a state for one registered table read, and finish waits in its own
// state on the rate unit: two 24x23 partial products, one wide add and a
// 71-step restoring division sharing a single 49-bit subtractor.
// One request is in work at a time; s_tready is high only in the idle
// state, and a result held in the output register does not block acceptance.
// A stalled receiver holds the result; the next request completes its work
// and waits until the output register is free.
// Reset clears the measurement state, the selection and adaptive_enable and
// sets variant_count to 1; table slots hold nothing defined until loaded.
`include "adaptive_bitrate_selector_defines.svh"

module adaptive_bitrate_selector
  import abrs_pkg::*;
#(
  parameter int MAX_VARIANTS = MAX_VARIANTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // variant_index, bandwidth_bps, byte_count, now_us, zero pad
  input  logic [S_TDATA_W-1:0] s_tdata,
  // mode
  input  logic [MODE_W-1:0]    s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // selected_index, selected_bandwidth, measured_rate, switched, zero pad
  output logic [M_TDATA_W-1:0] m_tdata,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [CNT_W-1:0]     cfg_data
);

  localparam int DEPTH = (MAX_VARIANTS < 8) ? MAX_VARIANTS : 8;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam int CMP_W = RATE_W + 4;
  localparam int M_PAD = M_TDATA_W - (IDX_W + BW_W + RATE_W + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_RATE, ST_SEL_UP, ST_SEL_SET, ST_DONE
  } state_t;

  function automatic logic [CMP_W-1:0] times10(input logic [BW_W-1:0] x);
    logic [CMP_W-1:0] e;
    e = CMP_W'(x);
    return (e << 3) + (e << 1);
  endfunction

  function automatic logic [CMP_W-1:0] times9(input logic [BW_W-1:0] x);
    logic [CMP_W-1:0] e;
    e = CMP_W'(x);
    return (e << 3) + e;
  endfunction

  state_t              state;
  logic                enable;
  logic [CNT_W-1:0]    count;
  mode_t               mode_q;
  logic [IDX_W-1:0]    vidx_q;
  logic [BW_W-1:0]     bw_q;
  logic [BYTE_W-1:0]   bytes_q;
  logic [TIME_W-1:0]   now_q;
  logic [TOTAL_W-1:0]  byte_total;
  logic [TIME_W-1:0]   start_time;
  logic [RATE_W-1:0]   rate_now;
  logic [IDX_W-1:0]    cur_idx;
  logic [BW_W-1:0]     cur_bw;
  logic [IDX_W-1:0]    tgt_idx;
  logic                switched;
  logic [IDX_W-1:0]    out_idx;
  logic [BW_W-1:0]     out_bw;
  logic [RATE_W-1:0]   out_rate;
  logic                out_sw;

  logic [CNT_W-1:0]    limit;
  logic [CNT_W-1:0]    idx_up;
  logic [CNT_W-1:0]    idx_dn;
  logic                sel_zero;
  logic                sel_up;
  logic                sel_dn;
  logic [IDX_W-1:0]    rd_idx;
  logic                tbl_we;
  logic [BW_W-1:0]     tbl_rdata;
  logic [TOTAL_W:0]    add_sum;
  logic                rate_start;
  logic [TIME_W-1:0]   span;
  rate_sts_t           rate_sts;
  logic [RATE_W-1:0]   rate_q;

  assign s_tready = (state == ST_IDLE);
  assign m_tdata  = {{M_PAD{1'b0}}, out_sw, out_rate, out_bw, out_idx};

  always_comb begin
    limit    = (count > DEPTH_C) ? DEPTH_C : count;
    idx_up   = CNT_W'(cur_idx) + 1'b1;
    idx_dn   = CNT_W'(cur_idx) - 1'b1;
    sel_zero = (rate_now == '0);
    sel_up   = !sel_zero && (rate_now > cur_bw) && (idx_up < limit);
    sel_dn   = !sel_zero && !(rate_now > cur_bw)
               && (times9(rate_now) < times10(cur_bw))
               && (cur_idx != '0) && (idx_dn < limit);
    rd_idx   = sel_up ? idx_up[IDX_W-1:0] : (sel_dn ? idx_dn[IDX_W-1:0] : '0);
    tbl_we   = (state == ST_EXEC) && enable && (mode_q == MODE_LOAD)
               && (32'(vidx_q) < 32'(MAX_VARIANTS));
    add_sum  = {1'b0, byte_total} + (TOTAL_W + 1)'(bytes_q);
    span     = now_q - start_time;
    rate_start = (state == ST_EXEC) && enable && (mode_q == MODE_FINISH)
                 && (now_q > start_time);
  end

  abrs_table #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (vidx_q[AW-1:0]),
    .wdata (bw_q),
    .raddr (rd_idx[AW-1:0]),
    .rdata (tbl_rdata)
  );

  abrs_rate u_rate (
    .clk   (clk),
    .rst   (rst),
    .start (rate_start),
    .total (byte_total),
    .span  (span),
    .sts   (rate_sts),
    .rate  (rate_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b0;
      count  <= CNT_W'(1);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ENABLE: enable <= cfg_data[0];
        CFG_COUNT:  count  <= cfg_data;
        default:    enable <= enable;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      m_tvalid   <= 1'b0;
      byte_total <= '0;
      start_time <= '0;
      rate_now   <= '0;
      cur_idx    <= '0;
      cur_bw     <= '0;
    end else begin
      if (m_tvalid && m_tready && (state != ST_DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            mode_q   <= mode_t'(s_tuser);
            vidx_q   <= s_tdata[IDX_W-1:0];
            bw_q     <= s_tdata[IDX_W +: BW_W];
            bytes_q  <= s_tdata[IDX_W + BW_W +: BYTE_W];
            now_q    <= s_tdata[IDX_W + BW_W + BYTE_W +: TIME_W];
            switched <= 1'b0;
            state    <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (!enable) begin
            state <= ST_DONE;
          end else begin
            case (mode_q)
              MODE_BEGIN: begin
                byte_total <= '0;
                start_time <= now_q;
                state      <= ST_DONE;
              end
              MODE_ADD: begin
                byte_total <= add_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : add_sum[TOTAL_W-1:0];
                state      <= ST_DONE;
              end
              MODE_FINISH: begin
                if (now_q > start_time) begin
                  state <= ST_RATE;
                end else begin
                  rate_now <= {RATE_W{1'b1}};
                  state    <= ST_DONE;
                end
              end
              MODE_SELECT: begin
                tgt_idx <= rd_idx;
                if (sel_up) begin
                  state <= ST_SEL_UP;
                end else if (sel_zero || sel_dn) begin
                  state <= ST_SEL_SET;
                end else begin
                  state <= ST_DONE;
                end
              end
              default: begin
                state <= ST_DONE;
              end
            endcase
          end
        end
        ST_RATE: begin
          if (rate_sts.done) begin
            rate_now <= rate_q;
            state    <= ST_DONE;
          end
        end
        ST_SEL_UP: begin
          if (times10(rate_now) >= times9(tbl_rdata)) begin
            cur_idx  <= tgt_idx;
            cur_bw   <= tbl_rdata;
            switched <= (tgt_idx != cur_idx);
          end
          state <= ST_DONE;
        end
        ST_SEL_SET: begin
          cur_idx  <= tgt_idx;
          cur_bw   <= tbl_rdata;
          switched <= (tgt_idx != cur_idx);
          state    <= ST_DONE;
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            out_idx  <= cur_idx;
            out_bw   <= cur_bw;
            out_rate <= rate_now;
            out_sw   <= switched;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `ABRS_ASSERT_NEXT(a_accept_blocks, s_tvalid && s_tready, !s_tready, "ready after accept")
  `ABRS_ASSERT_NOW(a_rate_owned, rate_sts.busy, state == ST_RATE, "rate unit busy outside finish")
  `ABRS_ASSERT_NOW(a_result_from_done, $rose(m_tvalid), $past(state == ST_DONE), "result without done")

endmodule
